// File: sv/motor_speed_ramp_limiter_assert.svh
// Assertion macros shared by the speed ramp limiter RTL.
`ifndef MOTOR_SPEED_RAMP_LIMITER_ASSERT_SVH
`define MOTOR_SPEED_RAMP_LIMITER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define MSRL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define MSRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/msrl_pkg.sv
// Types and constants for the motor speed ramp limiter.
`default_nettype none

package msrl_pkg;

	localparam int FUNC_W = 3;
	localparam int RPM_W  = 16;
	localparam int PROF_W = 2;
	localparam int CMD_W  = 17;
	localparam int DUTY_W = 16;
	localparam int STEP_W = 4;

	// Command codes carried in func.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK  = 3'd0,
		FUNC_SET   = 3'd1,
		FUNC_BURST = 3'd2,
		FUNC_STOP  = 3'd3,
		FUNC_CAP   = 3'd4
	} func_t;

	// Ramp profile codes.
	localparam logic [PROF_W-1:0] PROFILE_GENTLE = 2'd0;
	localparam logic [PROF_W-1:0] PROFILE_NORMAL = 2'd1;
	localparam logic [PROF_W-1:0] PROFILE_FAST   = 2'd2;

	// Acceleration steps in half-rpm per tick.
	localparam logic [STEP_W-1:0] STEP_GENTLE = 4'd1;
	localparam logic [STEP_W-1:0] STEP_NORMAL = 4'd3;
	localparam logic [STEP_W-1:0] STEP_FAST   = 4'd8;

	// Request from the ramp core to the duty unit.
	typedef struct packed {
		logic             valid;
		logic [CMD_W-1:0] cmd;
	} duty_req_t;

endpackage

`default_nettype wire

// File: sv/msrl_duty.sv
// Duty pipeline: scales the commanded half-rpm to a Q0.16 duty and holds the result.
`default_nettype none

module msrl_duty #(
	parameter int MAX_RPM = 10000
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire msrl_pkg::duty_req_t        req,
	output logic                            req_ready,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [msrl_pkg::DUTY_W-1:0]     duty,
	output logic [msrl_pkg::CMD_W-1:0]      commanded_half_rpm
);
	import msrl_pkg::*;

	// Divisor and its scaled reciprocal, fixed at elaboration.
	localparam longint unsigned DIV   = 2 * MAX_RPM;
	localparam longint unsigned RECIP = (longint'(65535) << CMD_W) / DIV;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W  = CMD_W + RECIP_W;
	localparam int NUM_W   = CMD_W + DUTY_W;
	localparam logic [CMD_W-1:0]   DIV_L   = CMD_W'(DIV);
	localparam logic [RECIP_W-1:0] RECIP_L = RECIP_W'(RECIP);

	logic               v_s2;
	logic [CMD_W-1:0]   cmd_s2;
	logic               v_s3;
	logic [CMD_W-1:0]   cmd_s3;
	logic [DUTY_W-1:0]  q_s3;
	logic               sat_s3;
	logic               out_valid_q;
	logic [DUTY_W-1:0]  duty_q;
	logic [CMD_W-1:0]   cmd_q;
	logic               out_ready;
	logic               s3_ready;
	logic [PROD_W-1:0]  prod;
	logic [NUM_W-1:0]   num;
	logic [NUM_W-1:0]   qd;
	logic [NUM_W-1:0]   rem;
	logic [DUTY_W-1:0]  duty_next;

	// Each stage moves when the one after it is empty or moving.
	assign out_ready = !out_valid_q || !out_stall;
	assign s3_ready  = !v_s3 || out_ready;
	assign req_ready = !v_s2 || s3_ready;

	// Quotient estimate by reciprocal multiply; may fall one short.
	assign prod = PROD_W'(cmd_s2) * PROD_W'(RECIP_L);

	// Remainder check corrects the estimate by one.
	assign num = (NUM_W'(cmd_s3) << DUTY_W) - NUM_W'(cmd_s3);
	assign qd  = NUM_W'(q_s3) * NUM_W'(DIV_L);
	assign rem = num - qd;

	always_comb begin
		if (sat_s3) begin
			duty_next = '1;
		end else if (rem >= NUM_W'(DIV_L)) begin
			duty_next = DUTY_W'(q_s3 + 1'b1);
		end else begin
			duty_next = q_s3;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_ready) v_s2 <= req.valid;
			if (s3_ready) v_s3 <= v_s2;
			if (out_ready) out_valid_q <= v_s3;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (req_ready && req.valid) begin
			cmd_s2 <= req.cmd;
		end
		if (s3_ready && v_s2) begin
			cmd_s3 <= cmd_s2;
			q_s3   <= DUTY_W'(prod >> CMD_W);
			sat_s3 <= (cmd_s2 >= DIV_L);
		end
		if (out_ready && v_s3) begin
			duty_q <= duty_next;
			cmd_q  <= cmd_s3;
		end
	end

	assign out_valid          = out_valid_q;
	assign duty               = duty_q;
	assign commanded_half_rpm = cmd_q;

endmodule

`default_nettype wire

// File: sv/motor_speed_ramp_limiter.sv
// Top level of the motor speed ramp limiter: command register, ramp state and duty output.
`default_nettype none
`include "motor_speed_ramp_limiter_assert.svh"

// Motor speed setpoint ramp. Each request carries one command in func: a 1 ms
// tick, set target with a ramp profile, burst to the target at once, stop, or
// enforce a cap. The block keeps a target in rpm (saturated at MAX_RPM) and a
// commanded speed in half-rpm. A tick moves the commanded speed toward twice
// the target by 1, 3 or 8 half-rpm up (gentle, normal, fast; profile code 3
// ramps as normal) and four times that down, clamped at the target, and
// returns the Q0.16 duty floor(commanded*65535/(2*MAX_RPM)) with the new
// commanded speed. A stop returns duty 0. Other commands return nothing. The
// block takes one request every clock cycle while in_stall is low: the command
// is registered, the ramp state updates as the request leaves that register,
// and a reciprocal-multiply pipeline (stages s2 and s3, then an output
// register) forms the duty. A stall on the output backs up through that
// pipeline; requests that give no result keep flowing while the input
// register is free.
module motor_speed_ramp_limiter #(
	parameter int MAX_RPM = 10000
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [msrl_pkg::FUNC_W-1:0] func,
	input  wire logic [msrl_pkg::RPM_W-1:0]  rpm_value,
	input  wire logic [msrl_pkg::PROF_W-1:0] slew_profile,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [msrl_pkg::DUTY_W-1:0]     duty,
	output logic [msrl_pkg::CMD_W-1:0]      commanded_half_rpm
);
	import msrl_pkg::*;

	localparam logic [RPM_W-1:0] MAX_L = RPM_W'(MAX_RPM);

	logic               v_s1;
	logic [FUNC_W-1:0]  func_s1;
	logic [RPM_W-1:0]   rpm_s1;
	logic [PROF_W-1:0]  prof_s1;
	logic [RPM_W-1:0]   target_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [PROF_W-1:0]  ramp_q;
	logic [RPM_W-1:0]   target_next;
	logic [CMD_W-1:0]   cmd_next;
	logic [PROF_W-1:0]  ramp_next;
	logic               has_result;
	logic               retire;
	logic               stop_retire;
	logic               req_ready;
	duty_req_t          req;
	logic [RPM_W-1:0]   rpm_lim;
	logic [CMD_W-1:0]   goal;
	logic [CMD_W-1:0]   cap2;
	logic [STEP_W-1:0]  up;
	logic [STEP_W+1:0]  down;
	logic [CMD_W:0]     sum;
	logic [CMD_W-1:0]   diff;

	// The input register retires unless its result finds the duty pipeline full.
	assign retire   = v_s1 && (!has_result || req_ready);
	assign in_stall = v_s1 && !retire;

	assign rpm_lim = (rpm_s1 > MAX_L) ? MAX_L : rpm_s1;
	assign goal    = {target_q, 1'b0};
	assign cap2    = {rpm_s1, 1'b0};
	assign sum     = {1'b0, cmd_q} + (CMD_W + 1)'(up);
	assign diff    = cmd_q - goal;
	assign down    = {up, 2'b00};

	// Acceleration step of the stored profile.
	always_comb begin
		case (ramp_q)
			PROFILE_GENTLE: up = STEP_GENTLE;
			PROFILE_FAST:   up = STEP_FAST;
			default:        up = STEP_NORMAL;
		endcase
	end

	// Next ramp state for the command in the input register.
	always_comb begin
		target_next = target_q;
		cmd_next    = cmd_q;
		ramp_next   = ramp_q;
		has_result  = 1'b0;
		case (func_t'(func_s1))
			FUNC_TICK: begin
				has_result = 1'b1;
				if (cmd_q < goal) begin
					cmd_next = (sum > (CMD_W + 1)'(goal)) ? goal : CMD_W'(sum);
				end else if (cmd_q > goal) begin
					cmd_next = (diff > CMD_W'(down)) ? cmd_q - CMD_W'(down) : goal;
				end
			end
			FUNC_SET: begin
				target_next = rpm_lim;
				ramp_next   = prof_s1;
			end
			FUNC_BURST: begin
				target_next = rpm_lim;
				cmd_next    = {rpm_lim, 1'b0};
			end
			FUNC_STOP: begin
				has_result  = 1'b1;
				target_next = '0;
				cmd_next    = '0;
			end
			FUNC_CAP: begin
				if (target_q > rpm_s1) target_next = rpm_s1;
				if (cmd_q > cap2) cmd_next = cap2;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	// Input register valid flag and ramp state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			target_q <= '0;
			cmd_q    <= '0;
			ramp_q   <= PROFILE_NORMAL;
		end else begin
			if (!in_stall) v_s1 <= in_valid;
			if (retire) begin
				target_q <= target_next;
				cmd_q    <= cmd_next;
				ramp_q   <= ramp_next;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			rpm_s1  <= rpm_value;
			prof_s1 <= slew_profile;
		end
	end

	// Results go to the duty pipeline with the updated commanded speed.
	assign req.valid = v_s1 && has_result;
	assign req.cmd   = cmd_next;

	msrl_duty #(
		.MAX_RPM(MAX_RPM)
	) u_duty (
		.clk               (clk),
		.arst_n            (arst_n),
		.req               (req),
		.req_ready         (req_ready),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.duty              (duty),
		.commanded_half_rpm(commanded_half_rpm)
	);

	// A stop that leaves the input register must clear both speeds.
	assign stop_retire = retire && (func_s1 == FUNC_STOP);

	`MSRL_ASSERT(a_cmd_bound, cmd_q <= CMD_W'(2 * MAX_RPM), "commanded speed above full scale")
	`MSRL_ASSERT(a_target_bound, target_q <= MAX_L, "target above MAX_RPM")
	`MSRL_ASSERT_NEXT(a_stop_clears, stop_retire, {cmd_q, target_q} == '0, "stop left speed set")
	`MSRL_ASSERT_NEXT(a_hold, !retire, $stable({target_q, cmd_q, ramp_q}), "state moved when idle")

endmodule

`default_nettype wire
